>>> hw/rtl/ssd_pkg.sv
// Shared types, sizes and the distance function for the stable distance sort.
package ssd_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int DATA_W    = 32;
  localparam int DIST_W    = DATA_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_EMIT,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [DIST_W-1:0] key_distance(input logic signed [DATA_W-1:0] k,
                                                     input logic signed [DATA_W-1:0] v);
    logic [DIST_W-1:0] kx;
    logic [DIST_W-1:0] vx;
    kx = {k[DATA_W-1], k};
    vx = {v[DATA_W-1], v};
    if (k >= v) begin
      key_distance = kx - vx;
    end else begin
      key_distance = vx - kx;
    end
  endfunction

endpackage

>>> hw/rtl/ssd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module ssd_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/ssd_ctrl.sv
// Insertion and emission sequencer with the output register.
module ssd_ctrl import ssd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic signed [DATA_W-1:0] key_value,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     last,
  input  logic                     in_valid,
  output logic                     in_ready,
  output logic signed [DATA_W-1:0] value_res,
  output logic                     last_res,
  output logic                     overflow,
  output logic                     out_valid,
  input  logic                     out_ready,
  output mem_req_t                 mem_req,
  input  logic [DATA_W-1:0]        mem_rdata
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              dropped, dropped_next;
  logic [CNT_W-1:0]  pos, pos_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [DATA_W-1:0] val, val_next;
  logic              last_item, last_item_next;
  logic [DIST_W-1:0] dn, dn_next;
  logic              out_valid_next;
  logic [DATA_W-1:0] value_res_next;
  logic              last_res_next;
  logic              overflow_next;
  logic [CNT_W-1:0]  pos_m1;
  logic [CNT_W-1:0]  pos_m2;
  logic              accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign pos_m1   = pos - CNT_W'(1);
  assign pos_m2   = pos - CNT_W'(2);

  always_comb begin
    state_next     = state;
    count_next     = count;
    dropped_next   = dropped;
    pos_next       = pos;
    idx_next       = idx;
    val_next       = val;
    last_item_next = last_item;
    dn_next        = dn;
    value_res_next = value_res;
    last_res_next  = last_res;
    overflow_next  = overflow;
    out_valid_next = out_valid && !out_ready;
    mem_req        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          val_next       = value;
          last_item_next = last;
          dn_next        = key_distance(key_value, value);
          pos_next       = count;
          idx_next       = '0;
          if (count == CNT_W'(MAX_ITEMS)) begin
            dropped_next = 1'b1;
            if (last) begin
              state_next = ST_EMIT;
            end
          end else if (count == '0) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = '0;
            mem_req.wdata = value;
            count_next    = count + CNT_W'(1);
            if (last) begin
              state_next = ST_EMIT;
            end
          end else begin
            mem_req.raddr = ADDR_W'(count - CNT_W'(1));
            state_next    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos[ADDR_W-1:0];
        if (key_distance(key_value, mem_rdata) > dn) begin
          mem_req.wdata = mem_rdata;
          pos_next      = pos_m1;
          if (pos_m1 == '0) begin
            state_next = ST_PLACE;
          end else begin
            mem_req.raddr = pos_m2[ADDR_W-1:0];
          end
        end else begin
          mem_req.wdata = val;
          count_next    = count + CNT_W'(1);
          state_next    = last_item ? ST_EMIT : ST_IDLE;
        end
      end
      ST_PLACE: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos[ADDR_W-1:0];
        mem_req.wdata = val;
        count_next    = count + CNT_W'(1);
        state_next    = last_item ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (count == '0) begin
          dropped_next = 1'b0;
          state_next   = ST_IDLE;
        end else if (!out_valid || out_ready) begin
          mem_req.raddr = idx[ADDR_W-1:0];
          state_next    = ST_LOAD;
        end
      end
      ST_LOAD: begin
        out_valid_next = 1'b1;
        value_res_next = mem_rdata;
        overflow_next  = dropped;
        idx_next       = idx + CNT_W'(1);
        if (idx + CNT_W'(1) == count) begin
          last_res_next = 1'b1;
          count_next    = '0;
          dropped_next  = 1'b0;
          state_next    = ST_IDLE;
        end else begin
          last_res_next = 1'b0;
          state_next    = ST_EMIT;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      dropped   <= dropped_next;
      out_valid <= out_valid_next;
    end
    pos       <= pos_next;
    idx       <= idx_next;
    val       <= val_next;
    last_item <= last_item_next;
    dn        <= dn_next;
    value_res <= value_res_next;
    last_res  <= last_res_next;
    overflow  <= overflow_next;
  end

endmodule

>>> hw/rtl/stable_sort_by_distance.sv
// Top level: collects a set of values and emits them stably sorted by distance to key.
// An item is written directly into an empty store; otherwise the last entry is read and
// each stored entry at greater distance moves up one slot before the item is placed.
// Each emitted result needs one RAM read and then one output register load.
// Reset clears the key, the element count, the dropped flag and the output valid;
// the element RAM is not cleared, since only entries below the count are ever read.
module stable_sort_by_distance import ssd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     key_we,
  input  logic signed [DATA_W-1:0] key,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     last,
  input  logic                     in_valid,
  output logic                     in_ready,
  output logic signed [DATA_W-1:0] value_res,
  output logic                     last_res,
  output logic                     overflow,
  output logic                     out_valid,
  input  logic                     out_ready
);

  logic signed [DATA_W-1:0] key_value;
  mem_req_t                 mem_req;
  logic [DATA_W-1:0]        mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_value <= '0;
    end else if (key_we) begin
      key_value <= key;
    end
  end

  ssd_ram #(
    .DEPTH(MAX_ITEMS),
    .WIDTH(DATA_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_req.we),
    .waddr(mem_req.waddr),
    .wdata(mem_req.wdata),
    .raddr(mem_req.raddr),
    .rdata(mem_rdata)
  );

  ssd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .key_value(key_value),
    .value    (value),
    .last     (last),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .value_res(value_res),
    .last_res (last_res),
    .overflow (overflow),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .mem_req  (mem_req),
    .mem_rdata(mem_rdata)
  );

endmodule
